FILE: hw/rtl/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Shared constant for the page stride prefetcher.
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

  // Width of a byte address and of the prefetch address.
  localparam int ADDR_W = 32;

endpackage

`default_nettype wire

FILE: hw/rtl/page_stride_prefetcher.sv
// Flow: check, scan of all trackers, decision, update pass, then result load
//   (waits for a free output stage); an access to the previous one's line
//   skips to the result. One item at a time: two passes over the tracker
//   RAM (lookup scan, then rank/entry update) through its single read port.
// Reset: all trackers invalid, previous line zero; no clearing pass.
// ----------------------------------------------------------------------------
// page_stride_prefetcher
// Per-page stride prefetcher with LRU tracker allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module page_stride_prefetcher #(
  parameter int TRACKERS  = 16,
  parameter int LINE_BITS = 6,
  parameter int PAGE_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [psp_pkg::ADDR_W-1:0] in_access_addr,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_prefetch_valid,
  output logic [psp_pkg::ADDR_W-1:0]      out_prefetch_addr
);
  import psp_pkg::*;

  localparam int IDX_W  = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
  localparam int PAGE_W = ADDR_W - PAGE_BITS;
  localparam int LINE_W = ADDR_W - LINE_BITS;
  localparam int OFS_W  = PAGE_BITS - LINE_BITS;
  localparam int STR_W  = OFS_W + 1;
  localparam int TGT_W  = OFS_W + 2;
  localparam int RANK_W = IDX_W;
  localparam int ENT_W  = PAGE_W + OFS_W + STR_W + RANK_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TRACKERS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_UPD    = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [TRACKERS-1:0] valid_r, valid_nxt;
  logic [LINE_W-1:0]   prev_line_r, prev_line_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;

  // lookup scan results
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [OFS_W-1:0]    hit_ofs_r, hit_ofs_nxt;
  logic [STR_W-1:0]    hit_str_r, hit_str_nxt;
  logic [RANK_W-1:0]   hit_rank_r, hit_rank_nxt;
  logic                inv_r, inv_nxt;
  logic [IDX_W-1:0]    inv_idx_r, inv_idx_nxt;
  logic                vic_r, vic_nxt;
  logic [IDX_W-1:0]    vic_idx_r, vic_idx_nxt;
  logic [RANK_W-1:0]   vic_rank_r, vic_rank_nxt;

  // decision
  logic [IDX_W-1:0]    sel_r, sel_nxt;
  logic                was_valid_r, was_valid_nxt;
  logic [RANK_W-1:0]   old_rank_r, old_rank_nxt;
  logic [OFS_W-1:0]    new_ofs_r, new_ofs_nxt;
  logic [STR_W-1:0]    new_str_r, new_str_nxt;
  logic                pfv_r, pfv_nxt;
  logic [ADDR_W-1:0]   pfa_r, pfa_nxt;

  logic                wr_en;
  logic [ENT_W-1:0]    wr_data;
  logic [ENT_W-1:0]    rd_data_r;
  logic                can_load;
  logic                load;

  logic [PAGE_W-1:0]   cur_page;
  logic [LINE_W-1:0]   cur_line;
  logic [OFS_W-1:0]    cur_ofs;
  logic [PAGE_W-1:0]   d_page;
  logic [RANK_W-1:0]   d_rank;
  logic [OFS_W-1:0]    d_ofs;
  logic [STR_W-1:0]    d_str;
  logic [STR_W-1:0]    stride;
  logic [TGT_W-1:0]    target;

  assign cur_page = addr_r[ADDR_W-1:PAGE_BITS];
  assign cur_line = addr_r[ADDR_W-1:LINE_BITS];
  assign cur_ofs  = addr_r[LINE_BITS +: OFS_W];

  assign d_page = rd_data_r[ENT_W-1 -: PAGE_W];
  assign d_ofs  = rd_data_r[RANK_W+STR_W +: OFS_W];
  assign d_str  = rd_data_r[RANK_W +: STR_W];
  assign d_rank = rd_data_r[RANK_W-1:0];

  assign stride = STR_W'({1'b0, cur_ofs}) - STR_W'({1'b0, hit_ofs_r});
  assign target = TGT_W'({2'b00, cur_ofs}) + {stride[STR_W-1], stride};

  assign in_ready = (state_r == ST_IDLE);
  assign load     = (state_r == ST_EMIT);

  psp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TRACKERS),
    .AW    (IDX_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (cnt_r),
    .wr_data   (wr_data),
    .rd_addr   (cnt_nxt),
    .rd_data_r (rd_data_r)
  );

  psp_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (load),
    .pf_valid           (pfv_r),
    .pf_addr            (pfa_r),
    .can_load           (can_load),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_prefetch_valid (out_prefetch_valid),
    .out_prefetch_addr  (out_prefetch_addr)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    prev_line_nxt = prev_line_r;
    addr_nxt      = addr_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ofs_nxt   = hit_ofs_r;
    hit_str_nxt   = hit_str_r;
    hit_rank_nxt  = hit_rank_r;
    inv_nxt       = inv_r;
    inv_idx_nxt   = inv_idx_r;
    vic_nxt       = vic_r;
    vic_idx_nxt   = vic_idx_r;
    vic_rank_nxt  = vic_rank_r;
    sel_nxt       = sel_r;
    was_valid_nxt = was_valid_r;
    old_rank_nxt  = old_rank_r;
    new_ofs_nxt   = new_ofs_r;
    new_str_nxt   = new_str_r;
    pfv_nxt       = pfv_r;
    pfa_nxt       = pfa_r;
    wr_en         = 1'b0;
    wr_data       = {cur_page, new_ofs_r, new_str_r, RANK_W'(0)};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          addr_nxt  = in_access_addr;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        pfv_nxt = 1'b0;
        pfa_nxt = '0;
        if (cur_line == prev_line_r) begin
          state_nxt = ST_EMIT;
        end else begin
          prev_line_nxt = cur_line;
          hit_nxt       = 1'b0;
          inv_nxt       = 1'b0;
          vic_nxt       = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // entry cnt_r is on the read port
        if (valid_r[cnt_r]) begin
          if (!hit_r && d_page == cur_page) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = cnt_r;
            hit_ofs_nxt  = d_ofs;
            hit_str_nxt  = d_str;
            hit_rank_nxt = d_rank;
          end
          // victim search stops at the first free tracker
          if (!inv_r && (!vic_r || d_rank > vic_rank_r)) begin
            vic_nxt      = 1'b1;
            vic_idx_nxt  = cnt_r;
            vic_rank_nxt = d_rank;
          end
        end else if (!inv_r) begin
          inv_nxt     = 1'b1;
          inv_idx_nxt = cnt_r;
        end
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        cnt_nxt   = '0;
        state_nxt = ST_UPD;
        if (hit_r) begin
          sel_nxt       = hit_idx_r;
          was_valid_nxt = 1'b1;
          old_rank_nxt  = hit_rank_r;
          if (stride == '0) begin
            new_ofs_nxt = hit_ofs_r;
            new_str_nxt = hit_str_r;
          end else begin
            new_ofs_nxt = cur_ofs;
            new_str_nxt = stride;
            if (stride == hit_str_r && target[TGT_W-1:OFS_W] == 2'b00) begin
              pfv_nxt = 1'b1;
              pfa_nxt = {cur_page, target[OFS_W-1:0], LINE_BITS'(0)};
            end
          end
        end else begin
          sel_nxt       = inv_r ? inv_idx_r : vic_idx_r;
          was_valid_nxt = !inv_r;
          old_rank_nxt  = vic_rank_r;
          new_ofs_nxt   = cur_ofs;
          new_str_nxt   = '0;
        end
      end
      ST_UPD: begin
        if (cnt_r == sel_r) begin
          wr_en = 1'b1;
        end else if (valid_r[cnt_r] && (!was_valid_r || d_rank < old_rank_r)) begin
          // age by one rank
          wr_en   = 1'b1;
          wr_data = {rd_data_r[ENT_W-1:RANK_W], d_rank + 1'b1};
        end
        if (cnt_r == LAST) begin
          valid_nxt[sel_r] = 1'b1;
          state_nxt        = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      prev_line_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      prev_line_r <= prev_line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_ofs_r   <= hit_ofs_nxt;
    hit_str_r   <= hit_str_nxt;
    hit_rank_r  <= hit_rank_nxt;
    inv_r       <= inv_nxt;
    inv_idx_r   <= inv_idx_nxt;
    vic_r       <= vic_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_rank_r  <= vic_rank_nxt;
    sel_r       <= sel_nxt;
    was_valid_r <= was_valid_nxt;
    old_rank_r  <= old_rank_nxt;
    new_ofs_r   <= new_ofs_nxt;
    new_str_r   <= new_str_nxt;
    pfv_r       <= pfv_nxt;
    pfa_r       <= pfa_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/psp_ram.sv
// ----------------------------------------------------------------------------
// psp_ram
// Tracker store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/psp_out_stage.sv
// ----------------------------------------------------------------------------
// psp_out_stage
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_out_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire logic                      pf_valid,
  input  wire logic [psp_pkg::ADDR_W-1:0] pf_addr,
  output logic                           can_load,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_prefetch_valid,
  output logic [psp_pkg::ADDR_W-1:0]     out_prefetch_addr
);
  import psp_pkg::*;

  logic              valid_r;
  logic              pfv_r;
  logic [ADDR_W-1:0] addr_r;

  // free, or emptied by this cycle's transfer
  assign can_load           = !valid_r || out_ready;
  assign out_valid          = valid_r;
  assign out_prefetch_valid = pfv_r;
  assign out_prefetch_addr  = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      pfv_r  <= pf_valid;
      addr_r <= pf_addr;
    end
  end

endmodule

`default_nettype wire
